// File: rtl/core/vertex_dedup_index_table_unit_assert.svh
// ----------------------------------------------------------------------------
// vertex dedup index table assertion macros
// concurrent checks used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef VERTEX_DEDUP_INDEX_TABLE_UNIT_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define VDIT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vdit check failed");

// next-cycle implication
`define VDIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vdit check failed");

`endif

// File: rtl/core/vdit_pkg.sv
// ----------------------------------------------------------------------------
// vdit_pkg
// shared constants and types of the vertex dedup index table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vdit_pkg;

  localparam int TABLE_DEPTH    = 1024;
  localparam int MAX_COMPONENTS = 8;
  localparam int NUM_MATERIALS  = 16;
  localparam int NUM_CELLS      = 8;

  localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_CELLS;
  localparam int CELL_W      = $clog2(NUM_CELLS);
  localparam int SLOT_W      = $clog2(BANK_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int MAT_W       = 4;
  localparam int MAT_IDX_W   = $clog2(NUM_MATERIALS);
  localparam int LEN_W       = 4;
  localparam int COMP_W      = 32;
  localparam int INDEX_W     = 10;
  localparam int INDEX_LIMIT = 1024;
  localparam int COUNT_W     = $clog2(INDEX_LIMIT + 1);
  localparam int DRAIN_LEN   = NUM_CELLS + 1;
  localparam int DRAIN_W     = $clog2(DRAIN_LEN);

  localparam logic [COMP_W-1:0] NEG_ZERO = {1'b1, {(COMP_W-1){1'b0}}};

  typedef logic [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [MAT_W-1:0]                  material;
    logic [LEN_W-1:0]                  length;
    comp_t [MAX_COMPONENTS-1:0]        comp;
  } key_t;

  typedef struct packed {
    key_t               key;
    logic [INDEX_W-1:0] index;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } cell_rd_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } cell_wr_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
  } link_t;

endpackage

`default_nettype wire

// File: rtl/core/vdit_cell.sv
// ----------------------------------------------------------------------------
// vdit_cell
// one bank of table entries with its key compare and a stage of the hit chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vdit_cell import vdit_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cell_rd_t rd,
  input  logic     rd_live,
  input  cell_wr_t wr,
  input  logic     wr_sel,
  input  key_t     key,
  input  link_t    link_in,
  output link_t    link_out
);

  entry_t mem [BANK_DEPTH];
  entry_t rdata;
  logic   rvalid;
  logic   hit;
  link_t  link_q;

  always_ff @(posedge clk) begin
    if (wr.en && wr_sel) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      link_q <= '0;
    end else begin
      rvalid       <= rd.en && rd_live;
      link_q.hit   <= link_in.hit || hit;
      link_q.index <= hit ? rdata.index : link_in.index;
    end
  end

  assign hit      = rvalid && (rdata.key == key);
  assign link_out = link_q;

endmodule

`default_nettype wire

// File: rtl/core/vertex_dedup_index_table_unit.sv
// ----------------------------------------------------------------------------
// vertex_dedup_index_table_unit
// look-up-or-insert table of vertex keys with per-material index counters
// ----------------------------------------------------------------------------
// A lookup item accepted on start returns its one result with done: every cell
// reads its 128-entry bank one slot per cycle in the scan state, then the hit
// travels down the 8-cell chain in the drain state, and the finish state
// decides and, for a new key with room, writes. A clear item answers on the
// next cycle. For a lookup item, busy is high from acceptance until the result
// cycle, in which a new item may already be started. The result is shown for
// exactly one cycle with done and is lost if not taken then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_index_table_unit import vdit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [MAT_W-1:0]   material,
  input  logic [LEN_W-1:0]   component_count,
  input  logic [COMP_W-1:0]  component_0,
  input  logic [COMP_W-1:0]  component_1,
  input  logic [COMP_W-1:0]  component_2,
  input  logic [COMP_W-1:0]  component_3,
  input  logic [COMP_W-1:0]  component_4,
  input  logic [COMP_W-1:0]  component_5,
  input  logic [COMP_W-1:0]  component_6,
  input  logic [COMP_W-1:0]  component_7,
  output logic               done,
  output logic [INDEX_W-1:0] vertex_index,
  output logic               was_new,
  output logic               table_full
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]         state;
  logic [SLOT_W-1:0]  slot;
  logic [DRAIN_W-1:0] drain_cnt;
  key_t               key;
  key_t               key_in;
  logic               found;
  logic [INDEX_W-1:0] found_index;
  logic [FILL_W-1:0]  fill;
  logic [COUNT_W-1:0] mat_count [NUM_MATERIALS];
  logic [COUNT_W-1:0] mat_cnt_cur;
  logic [LEN_W-1:0]   len_sat;
  comp_t [MAX_COMPONENTS-1:0] comp_in;
  logic               full_cond;
  cell_rd_t           rd;
  cell_wr_t           wr;
  link_t              chain [NUM_CELLS+1];

  assign comp_in = {component_7, component_6, component_5, component_4,
                    component_3, component_2, component_1, component_0};

  assign len_sat = (component_count > LEN_W'(MAX_COMPONENTS)) ?
                   LEN_W'(MAX_COMPONENTS) : component_count;

  always_comb begin
    key_in.material = material;
    key_in.length   = len_sat;
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      if (LEN_W'(i) < len_sat && comp_in[i] != NEG_ZERO) begin
        key_in.comp[i] = comp_in[i];
      end else begin
        key_in.comp[i] = '0;
      end
    end
  end

  assign mat_cnt_cur = mat_count[key.material[MAT_IDX_W-1:0]];
  assign full_cond   = (fill == FILL_W'(TABLE_DEPTH)) ||
                       (mat_cnt_cur >= COUNT_W'(INDEX_LIMIT));

  assign rd.en   = (state == ST_SCAN);
  assign rd.addr = slot;

  assign wr.en         = (state == ST_FINISH) && !found && !full_cond;
  assign wr.addr       = fill[CELL_W +: SLOT_W];
  assign wr.data.key   = key;
  assign wr.data.index = mat_cnt_cur[INDEX_W-1:0];

  assign chain[0] = '0;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    logic live;
    logic sel;
    assign live = FILL_W'({slot, CELL_W'(c)}) < fill;
    assign sel  = (fill[CELL_W-1:0] == CELL_W'(c));
    vdit_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rd       (rd),
      .rd_live  (live),
      .wr       (wr),
      .wr_sel   (sel),
      .key      (key),
      .link_in  (chain[c]),
      .link_out (chain[c+1])
    );
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot         <= '0;
      drain_cnt    <= '0;
      found        <= 1'b0;
      fill         <= '0;
      done         <= 1'b0;
      vertex_index <= '0;
      was_new      <= 1'b0;
      table_full   <= 1'b0;
      for (int m = 0; m < NUM_MATERIALS; m++) begin
        mat_count[m] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (req_type) begin
              fill         <= '0;
              done         <= 1'b1;
              vertex_index <= '0;
              was_new      <= 1'b0;
              table_full   <= 1'b0;
              for (int m = 0; m < NUM_MATERIALS; m++) begin
                mat_count[m] <= '0;
              end
            end else begin
              key   <= key_in;
              found <= 1'b0;
              slot  <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          slot <= slot + SLOT_W'(1);
          if (slot == SLOT_W'(BANK_DEPTH - 1)) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + DRAIN_W'(1);
          if (drain_cnt == DRAIN_W'(DRAIN_LEN - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (found) begin
            vertex_index <= found_index;
            was_new      <= 1'b0;
            table_full   <= 1'b0;
          end else if (full_cond) begin
            vertex_index <= '0;
            was_new      <= 1'b0;
            table_full   <= 1'b1;
          end else begin
            vertex_index <= mat_cnt_cur[INDEX_W-1:0];
            was_new      <= 1'b1;
            table_full   <= 1'b0;
            fill         <= fill + FILL_W'(1);
            mat_count[key.material[MAT_IDX_W-1:0]] <= mat_cnt_cur + COUNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if ((state == ST_SCAN || state == ST_DRAIN) && chain[NUM_CELLS].hit) begin
        found       <= 1'b1;
        found_index <= chain[NUM_CELLS].index;
      end
    end
  end

`include "vertex_dedup_index_table_unit_assert.svh"

  `VDIT_ASSERT_SAME(a_flags_exclusive, done, !(was_new && table_full))
  `VDIT_ASSERT_NEXT(a_clear_result, start && !busy && req_type,
                    done && vertex_index == '0 && !was_new && !table_full)
  `VDIT_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FILL_W'(TABLE_DEPTH))
  `VDIT_ASSERT_NEXT(a_insert_grows, wr.en, fill == $past(fill) + FILL_W'(1))

endmodule

`default_nettype wire
